/* hw/rtl/acfa_pkg.sv */
// shared constants and types for the alternating-class fifo arbiter
`default_nettype none

package acfa_pkg;

    localparam int DEPTH      = 16;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 5;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    localparam logic [OP_W-1:0] OP_PUT_ONE = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT_TWO = 2'd1;
    localparam logic [OP_W-1:0] OP_GET     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_PUT_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GET_OK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    // per-cell control: shift from the neighbour or load the put data
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    // arbitration outcome for the current request
    typedef struct packed {
        logic take_put;
        logic take_get;
    } decision_t;

    // arbiter state as seen by the datapath
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               expect_one;
        logic               hold;
    } arb_state_t;

endpackage

`default_nettype wire

/* hw/rtl/acfa_cell.sv */
// one storage cell of the shifting fifo chain
`default_nettype none

module acfa_cell (
    input  wire                        aclk,
    input  acfa_pkg::cell_ctl_t        ctl,
    input  wire [acfa_pkg::DATA_W-1:0] neighbour_data,
    input  wire [acfa_pkg::DATA_W-1:0] put_data,
    output logic [acfa_pkg::DATA_W-1:0] data
);
    import acfa_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.shift) begin
            data_next = neighbour_data;
        end else if (ctl.load) begin
            data_next = put_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/acfa_ctrl.sv */
// arbitration state: fill count, expected class and hold flag
`default_nettype none

module acfa_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      accept,
    input  wire [acfa_pkg::OP_W-1:0] opcode,
    output acfa_pkg::decision_t      dec,
    output acfa_pkg::arb_state_t     state
);
    import acfa_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               expect_one_reg;
    logic               expect_one_next;
    logic               hold_reg;
    logic               hold_next;
    logic               is_put;
    logic               right_class;
    logic               set_hold;

    always_comb begin
        is_put      = (opcode == OP_PUT_ONE) || (opcode == OP_PUT_TWO);
        right_class = is_put && ((opcode == OP_PUT_ONE) == expect_one_reg);
        dec         = '0;
        set_hold    = 1'b0;
        if (opcode == OP_PUT_ONE || opcode == OP_PUT_TWO || opcode == OP_GET) begin
            if (count_reg == '0) begin
                dec.take_put = right_class;
            end else if (count_reg >= COUNT_W'(DEPTH)) begin
                dec.take_get = (opcode == OP_GET);
            end else if (hold_reg) begin
                dec.take_put = right_class;
            end else if (opcode == OP_GET) begin
                dec.take_get = 1'b1;
            end else if (right_class) begin
                dec.take_put = 1'b1;
            end else begin
                set_hold = 1'b1;
            end
        end
    end

    always_comb begin
        count_next      = count_reg;
        expect_one_next = expect_one_reg;
        hold_next       = hold_reg;
        if (accept) begin
            if (dec.take_put) begin
                count_next      = count_reg + 1'b1;
                expect_one_next = !expect_one_reg;
                hold_next       = 1'b0;
            end else if (dec.take_get) begin
                count_next = count_reg - 1'b1;
            end else if (set_hold) begin
                hold_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            expect_one_reg <= 1'b1;
            hold_reg       <= 1'b0;
        end else begin
            count_reg      <= count_next;
            expect_one_reg <= expect_one_next;
            hold_reg       <= hold_next;
        end
    end

    assign state.count      = count_reg;
    assign state.expect_one = expect_one_reg;
    assign state.hold       = hold_reg;

endmodule

`default_nettype wire

/* hw/rtl/alternating_class_fifo_arbiter.sv */
// top level: alternating-class fifo arbiter over a shifting cell chain
//
// Input channel s_*: one request per beat, kind in s_tuser (0 put class one,
// 1 put class two, 2 get), the data word for a put in s_tdata.
// Output channel m_*: exactly one result beat per request, status in m_tuser
// (0 put taken, 1 get taken, 2 refused), get value and fill level in m_tdata.
// Storage is a row of 16 cells; the oldest word sits in cell 0, a get shifts
// every cell one place towards it, a put loads the cell at the fill count.
// A request accepted by the fifo has its result on m_* from the next cycle. One
// request per cycle is taken, set by the single result register in front of
// m_*; s_tready stays high while that register is empty or being drained in
// the same cycle.
// When the receiver stalls, the result is held and s_tready drops until it is
// taken. Reset empties the fifo, expects class one, clears the hold flag and
// the result valid flag; cell contents are not cleared and never read unwritten.
`default_nettype none

module alternating_class_fifo_arbiter (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [acfa_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] put_value
    input  wire [acfa_pkg::OP_W-1:0]      s_tuser,  // [1:0] opcode
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [acfa_pkg::M_TDATA_W-1:0] m_tdata, // [31:0] get_value, [36:32] fill_level
    output logic [acfa_pkg::STATUS_W-1:0] m_tuser   // [1:0] status
);
    import acfa_pkg::*;

    logic                 s_accept;
    decision_t            dec;
    arb_state_t           arb;
    cell_ctl_t            cell_ctl [DEPTH];
    logic [DATA_W-1:0]    cell_q   [DEPTH];
    logic [DATA_W-1:0]    neighbour[DEPTH];
    logic [COUNT_W-1:0]   fill_after;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [DATA_W-1:0]    get_value_reg;
    logic [FILL_W-1:0]    fill_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    acfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .opcode  (s_tuser),
        .dec     (dec),
        .state   (arb)
    );

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            if (i == DEPTH - 1) begin : g_tail
                assign neighbour[i] = '0;
            end else begin : g_body
                assign neighbour[i] = cell_q[i+1];
            end
            assign cell_ctl[i].shift = s_accept && dec.take_get;
            assign cell_ctl[i].load  = s_accept && dec.take_put
                                       && (arb.count == COUNT_W'(i));
            acfa_cell u_cell (
                .aclk           (aclk),
                .ctl            (cell_ctl[i]),
                .neighbour_data (neighbour[i]),
                .put_data       (s_tdata[DATA_W-1:0]),
                .data           (cell_q[i])
            );
        end
    endgenerate

    always_comb begin
        fill_after = arb.count;
        if (dec.take_put) begin
            fill_after = arb.count + 1'b1;
        end else if (dec.take_get) begin
            fill_after = arb.count - 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fill_reg <= FILL_W'(fill_after);
            if (dec.take_put) begin
                status_reg    <= ST_PUT_OK;
                get_value_reg <= '0;
            end else if (dec.take_get) begin
                status_reg    <= ST_GET_OK;
                get_value_reg <= cell_q[0];
            end else begin
                status_reg    <= ST_REFUSED;
                get_value_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - FILL_W){1'b0}}, fill_reg, get_value_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        arb.count <= COUNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_put_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && dec.take_put) |=> (arb.expect_one != $past(arb.expect_one)))
        else $error("expected class did not toggle after put");

    a_refuse_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !dec.take_put && !dec.take_get) |=> (arb.count == $past(arb.count)))
        else $error("refused request changed fill count");

    a_hold_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        arb.hold |-> (arb.count != '0 && arb.count < COUNT_W'(DEPTH)))
        else $error("hold flag set outside partly filled state");
`endif

endmodule

`default_nettype wire
